@@ hdl/lsqu_pkg.sv @@
// shared types and constants for the load/store queue unit
package lsqu_pkg;
  localparam int LQ_DEPTH_D    = 8;
  localparam int SQ_DEPTH_D    = 8;
  localparam int ROB_ENTRIES_D = 32;
  localparam int MEM_BYTES_D   = 65536;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LW  = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd3;
  localparam logic [2:0] LK_LHU = 3'd4;

  localparam logic [1:0] SK_SB = 2'd0;
  localparam logic [1:0] SK_SH = 2'd1;
  localparam logic [1:0] SK_SW = 2'd2;

  localparam logic BUS_ADDR   = 1'b0;
  localparam logic BUS_COMMIT = 1'b1;

  localparam logic [0:0] REG_LOAD_WAIT  = 1'd0;
  localparam logic [0:0] REG_STORE_WAIT = 1'd1;

  typedef struct packed {
    logic        flush;
    logic        load_in_valid;
    logic [4:0]  load_in_tag;
    logic [2:0]  load_in_kind;
    logic        store_in_valid;
    logic [4:0]  store_in_tag;
    logic [1:0]  store_in_kind;
    logic        bus_valid;
    logic        bus_kind;
    logic [4:0]  bus_tag;
    logic [31:0] bus_value;
  } in_item_t;

  typedef struct packed {
    logic        wb_valid;
    logic [4:0]  wb_tag;
    logic [31:0] wb_value;
    logic        store_done;
    logic [4:0]  store_done_tag;
    logic        load_queue_full;
    logic        store_queue_full;
    logic [1:0]  overflow_code;
  } out_item_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [4:0]  tag;
    logic [2:0]  kind;
    logic        known;
    logic [31:0] addr;
  } q_entry_t;

  function automatic logic [31:0] load_extend(input logic [2:0] kind, input logic [31:0] raw);
    logic [31:0] v;
    case (kind)
      LK_LB:   v = {{24{raw[7]}}, raw[7:0]};
      LK_LH:   v = {{16{raw[15]}}, raw[15:0]};
      LK_LW:   v = raw;
      LK_LBU:  v = {24'd0, raw[7:0]};
      LK_LHU:  v = {16'd0, raw[15:0]};
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

@@ hdl/lsqu_ram.sv @@
// generic single-port ram with registered read
module lsqu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[addr] <= wdata;
    rdata <= mem_r[addr];
  end
endmodule

@@ hdl/lsqu_data_mem.sv @@
// four byte-lane data memory with clearing pass and wrap-around access
module lsqu_data_mem #(
  parameter int MEM_BYTES = lsqu_pkg::MEM_BYTES_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic        wr_en,
  input  logic [31:0] addr,
  input  logic [3:0]  wr_mask,
  input  logic [31:0] wr_data,
  output logic [31:0] rd_data,
  output logic        clear_busy
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam int BANK_DEPTH = (MEM_BYTES + 3) / 4;
  localparam int BW = $clog2(BANK_DEPTH);

  logic [BW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_r, clr_nxt;
  logic [1:0]    lane0_r;

  logic [BW-1:0] bank_addr [4];
  logic [7:0]    bank_wd   [4];
  logic [7:0]    bank_rd   [4];
  logic          bank_we   [4];

  always_comb begin
    clr_nxt = clr_r;
    clr_idx_nxt = clr_idx_r;
    if (clr_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == BW'(BANK_DEPTH - 1)) clr_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
    if (rd_en) lane0_r <= 2'(addr % MEM_BYTES);
  end

  assign clear_busy = clr_r;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic [AW-1:0] byte_a;
    logic [1:0]    k;
    always_comb begin
      // access byte that falls in this lane, wrapped into the memory
      k = 2'(g) - 2'(addr % MEM_BYTES);
      byte_a = AW'((33'(addr) + 33'(k)) % MEM_BYTES);
      bank_addr[g] = clr_r ? clr_idx_r : BW'(byte_a >> 2);
      bank_we[g] = clr_r | (wr_en & wr_mask[k]);
      bank_wd[g] = clr_r ? 8'd0 : wr_data[8*k +: 8];
    end
    lsqu_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank (
      .clk(clk), .we(bank_we[g]), .addr(bank_addr[g]),
      .wdata(bank_wd[g]), .rdata(bank_rd[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rd_data[8*i +: 8] = bank_rd[2'(lane0_r + 2'(i))];
    end
  end
endmodule

@@ hdl/lsqu_queue.sv @@
// in-order queue with tag match for address capture
module lsqu_queue #(
  parameter int DEPTH = lsqu_pkg::LQ_DEPTH_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               flush,
  input  logic               push,
  input  lsqu_pkg::q_entry_t push_entry,
  input  logic               match_en,
  input  logic [4:0]         match_tag,
  input  logic [31:0]        match_addr,
  input  logic               pop,
  output lsqu_pkg::q_entry_t head,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [$clog2(DEPTH+1)-1:0] count_after_push
);
  import lsqu_pkg::*;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  q_entry_t      ent_r [DEPTH];
  q_entry_t      ent_nxt [DEPTH];
  logic [IW-1:0] head_r, head_nxt, tail;
  logic [IW:0]   tail_sum;
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_f;
  logic [IW-1:0] head_f;
  logic          do_push;

  always_comb begin
    head_f = flush ? '0 : head_r;
    cnt_f = flush ? '0 : cnt_r;
    do_push = push && (cnt_f < CW'(DEPTH));
    tail_sum = (IW+1)'(head_f) + (IW+1)'(cnt_f);
    tail = (tail_sum >= (IW+1)'(DEPTH)) ? IW'(tail_sum - (IW+1)'(DEPTH)) : IW'(tail_sum);
    count_after_push = cnt_f + CW'(do_push);
    head_nxt = head_f;
    cnt_nxt = count_after_push;
    if (pop) begin
      head_nxt = (head_f == IW'(DEPTH - 1)) ? '0 : head_f + 1'b1;
      cnt_nxt = count_after_push - 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      if (do_push && tail == IW'(i)) ent_nxt[i] = push_entry;
      if (match_en && ent_nxt[i].tag == match_tag) begin
        ent_nxt[i].known = 1'b1;
        ent_nxt[i].addr = match_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
    end
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  assign head = ent_r[head_f];
  assign count = cnt_f;
endmodule

@@ hdl/load_store_queue_unit.sv @@
// top level of the load/store queue unit
//  channel | direction | handshake
//  in_     | input     | in_valid / in_stall, in_data
//  out_    | output    | out_valid / out_stall, out_data
//  cfg_    | input     | apb write/read of load_wait, store_wait
// a tick is accepted only in the idle phase: the data memory read starts in
// the accept cycle, then the result is registered and the state updated.
// after reset a clearing pass zeroes memory; no transfer is accepted during it.
// a stalled result holds and blocks the next tick.
module load_store_queue_unit #(
  parameter int LQ_DEPTH = lsqu_pkg::LQ_DEPTH_D,
  parameter int SQ_DEPTH = lsqu_pkg::SQ_DEPTH_D,
  parameter int MEM_BYTES = lsqu_pkg::MEM_BYTES_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsqu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lsqu_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import lsqu_pkg::*;
  localparam int LCW = $clog2(LQ_DEPTH+1);
  localparam int SCW = $clog2(SQ_DEPTH+1);
  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_EXEC = 1'b1;

  logic [3:0]  load_wait_r, store_wait_r;
  logic [31:0] tick_r;
  logic [3:0]  ltimer_r, stimer_r;
  logic        store_go_r;
  logic [31:0] commit_r;
  logic        ph_r;
  in_item_t    it_r;
  out_item_t   out_r;
  logic        ovalid_r;

  logic        clr_busy, accept, exec;
  in_item_t    cur;
  q_entry_t    lq_head, sq_head, new_l, new_s;
  logic [LCW-1:0] lq_cnt, lq_cnt_p;
  logic [SCW-1:0] sq_cnt, sq_cnt_p;
  logic        lpop, spop, match_en;
  logic [3:0]  lw_eff, sw_eff;
  logic        l_fire, s_fire, l_read_phase;
  logic [31:0] mem_rd;
  logic [3:0]  wmask;
  logic [3:0]  lt_f, st_f;
  logic        go_f;
  logic [31:0] st_addr;

  assign in_stall = clr_busy || ph_r == PH_EXEC || (ovalid_r && out_stall);
  assign accept = in_valid && !in_stall;
  assign exec = ph_r == PH_EXEC;
  assign cur = it_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_STORE_WAIT) ? {28'd0, store_wait_r}
                                                       : {28'd0, load_wait_r};

  always_comb begin
    lw_eff = (load_wait_r == 4'd0) ? 4'd1 : load_wait_r;
    sw_eff = (store_wait_r == 4'd0) ? 4'd1 : store_wait_r;
    lt_f = cur.flush ? 4'd0 : ltimer_r;
    st_f = cur.flush ? 4'd0 : stimer_r;
    go_f = cur.flush ? 1'b0 : store_go_r;
    new_l = '{stamp: tick_r, tag: cur.load_in_tag, kind: cur.load_in_kind,
              known: 1'b0, addr: 32'd0};
    new_s = '{stamp: tick_r, tag: cur.store_in_tag, kind: {1'b0, cur.store_in_kind},
              known: 1'b0, addr: 32'd0};
    match_en = exec && cur.bus_valid && cur.bus_kind == BUS_ADDR;
    st_addr = (match_en && sq_head.tag == cur.bus_tag) ? cur.bus_value : sq_head.addr;
    l_fire = lt_f != 4'd0 && lt_f >= lw_eff && lq_cnt_p != '0;
    s_fire = st_f != 4'd0 && st_f >= sw_eff && sq_cnt_p != '0;
    lpop = exec && l_fire;
    spop = exec && s_fire;
    case (sq_head.kind[1:0])
      SK_SB:   wmask = 4'b0001;
      SK_SH:   wmask = 4'b0011;
      SK_SW:   wmask = 4'b1111;
      default: wmask = 4'b0000;
    endcase
  end

  // memory read in the accept cycle for the load head, with an address that
  // arrives on the bus in the same tick taking precedence
  logic [31:0] rd_addr_early;
  always_comb begin
    l_read_phase = accept;
    rd_addr_early = lq_head.addr;
    if (in_data.bus_valid && in_data.bus_kind == BUS_ADDR && in_data.bus_tag == lq_head.tag)
      rd_addr_early = in_data.bus_value;
  end

  lsqu_queue #(.DEPTH(LQ_DEPTH)) u_lq (
    .clk(clk), .rst_n(rst_n), .flush(exec && cur.flush), .push(exec && cur.load_in_valid),
    .push_entry(new_l), .match_en(match_en), .match_tag(cur.bus_tag),
    .match_addr(cur.bus_value), .pop(lpop), .head(lq_head), .count(lq_cnt),
    .count_after_push(lq_cnt_p)
  );

  lsqu_queue #(.DEPTH(SQ_DEPTH)) u_sq (
    .clk(clk), .rst_n(rst_n), .flush(exec && cur.flush), .push(exec && cur.store_in_valid),
    .push_entry(new_s), .match_en(match_en), .match_tag(cur.bus_tag),
    .match_addr(cur.bus_value), .pop(spop), .head(sq_head), .count(sq_cnt),
    .count_after_push(sq_cnt_p)
  );

  lsqu_data_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk(clk), .rst_n(rst_n), .rd_en(l_read_phase),
    .wr_en(spop), .addr(spop ? st_addr : rd_addr_early),
    .wr_mask(wmask), .wr_data(commit_r), .rd_data(mem_rd), .clear_busy(clr_busy)
  );

  out_item_t res;
  logic [3:0] lt_n, st_n;
  logic       go_n;
  logic [31:0] commit_n;
  logic        lq_start;
  logic        l_known;
  logic [31:0] l_stamp, s_stamp;
  always_comb begin
    res = '0;
    res.overflow_code = {cur.store_in_valid && sq_cnt >= SCW'(SQ_DEPTH),
                         cur.load_in_valid && lq_cnt >= LCW'(LQ_DEPTH)};
    go_n = go_f;
    commit_n = commit_r;
    if (cur.bus_valid && cur.bus_kind == BUS_COMMIT && st_f == 4'd0 && sq_cnt != '0
        && sq_head.tag == cur.bus_tag && sq_head.known) begin
      go_n = 1'b1;
      commit_n = cur.bus_value;
    end
    // an empty queue before this tick means the head is the entry pushed now
    if (lq_cnt == '0) begin
      l_known = match_en && cur.load_in_tag == cur.bus_tag;
      l_stamp = tick_r;
    end else begin
      l_known = lq_head.known || (match_en && lq_head.tag == cur.bus_tag);
      l_stamp = lq_head.stamp;
    end
    s_stamp = (sq_cnt == '0) ? tick_r : sq_head.stamp;
    lq_start = lq_cnt_p != '0 && l_known && (sq_cnt_p == '0 || l_stamp <= s_stamp);
    if (lt_f == 4'd0) lt_n = lq_start ? 4'd1 : 4'd0;
    else if (lt_f >= lw_eff) lt_n = 4'd0;
    else lt_n = lt_f + 4'd1;
    if (l_fire) begin
      res.wb_valid = 1'b1;
      res.wb_tag = lq_head.tag;
      res.wb_value = load_extend(lq_head.kind, mem_rd);
    end
    if (st_f == 4'd0) begin
      st_n = go_n ? 4'd1 : 4'd0;
      if (go_n) go_n = 1'b0;
    end else begin
      st_n = (st_f >= sw_eff) ? 4'd0 : st_f + 4'd1;
    end
    if (s_fire) begin
      res.store_done = 1'b1;
      res.store_done_tag = sq_head.tag;
    end
    res.load_queue_full = lq_cnt_p >= LCW'(LQ_DEPTH);
    res.store_queue_full = sq_cnt_p >= SCW'(SQ_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_wait_r <= 4'd3;
      store_wait_r <= 4'd3;
      tick_r <= '0;
      ltimer_r <= '0;
      stimer_r <= '0;
      store_go_r <= 1'b0;
      commit_r <= '0;
      ph_r <= PH_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == REG_LOAD_WAIT) load_wait_r <= cfg_pwdata[3:0];
        else store_wait_r <= cfg_pwdata[3:0];
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (accept) ph_r <= PH_EXEC;
      if (exec) begin
        ph_r <= PH_IDLE;
        ltimer_r <= lt_n;
        stimer_r <= st_n;
        store_go_r <= go_n;
        commit_r <= commit_n;
        tick_r <= tick_r + 32'd1;
        ovalid_r <= 1'b1;
      end
    end
    if (accept) it_r <= in_data;
    if (exec) out_r <= res;
  end

  assign out_valid = ovalid_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept) else $error("transfer during clear");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid) else $error("tick without result");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data)) else $error("result changed");
`endif
endmodule
